// ===== hdl/awsa_pkg.sv =====
// Shared types, widths and register codes for the affine warp source address block.
package awsa_pkg;

    // Field and register widths
    localparam int COORD_W     = 11;  // output pixel coordinate
    localparam int COEF_W      = 32;  // Q16.16 coefficient or offset
    localparam int DIM_W       = 13;  // source width or height register
    localparam int SRC_COORD_W = 12;  // source column or row
    localparam int IDX_W       = 24;  // linear source index
    localparam int CFG_IDX_W   = 3;   // register index
    localparam int CFG_DATA_W  = 32;  // configuration write data

    // Datapath widths: 32-bit signed coefficient times 12-bit zero-extended coordinate,
    // then a three-term sum.
    localparam int PROD_W     = COEF_W + COORD_W + 1;
    localparam int ACC_W      = PROD_W + 2;
    localparam int PIX_PROD_W = SRC_COORD_W + DIM_W;
    localparam int FRAME_W    = 14;   // holds the largest output frame size

    // Parameter defaults
    localparam int OUT_WIDTH_DEF  = 2048;
    localparam int OUT_HEIGHT_DEF = 2048;
    localparam int FRAC_BITS_DEF  = 16;

    // Largest usable source dimension
    localparam logic [DIM_W-1:0] SRC_DIM_MAX = 13'd4096;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_XX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_XY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd7;

    // Register reset values
    localparam logic [COEF_W-1:0] COEF_ONE  = 32'd65536;
    localparam logic [COEF_W-1:0] COEF_ZERO = 32'd0;
    localparam logic [DIM_W-1:0]  DIM_RST   = 13'd1;

    // Stage 1 to stage 2: products
    typedef struct packed {
        logic                     in_frame;
        logic signed [PROD_W-1:0] prod_xx;
        logic signed [PROD_W-1:0] prod_xy;
        logic signed [PROD_W-1:0] prod_yx;
        logic signed [PROD_W-1:0] prod_yy;
    } mul_t;

    // Stage 2 to stage 3: mapped source point
    typedef struct packed {
        logic                    in_frame;
        logic signed [ACC_W-1:0] sx;
        logic signed [ACC_W-1:0] sy;
    } sum_t;

    // Stage 3 to stage 4: hit and truncated source coordinates
    typedef struct packed {
        logic                   hit;
        logic [SRC_COORD_W-1:0] px;
        logic [SRC_COORD_W-1:0] py;
    } bound_t;

endpackage

// ===== hdl/affine_warp_source_address.sv =====
// Top level of the inverse affine warp source address generator.
//
//  channel  direction  handshake              beat contents
//  in       sink       in_valid / in_ready    out_x, out_y
//  out      source     out_valid / out_ready  hit, src_x, src_y, src_index
//  cfg      sink       cfg_wr_en              cfg_index, cfg_data
//
// Each beat passes four register stages: product, sum, bounds test, index
// multiply-add. The result is held in the index stage register until it is taken.
// One beat enters per cycle as long as the output side keeps taking beats;
// the four stage registers and their valid bits set that figure.
// Reset clears the valid bits and loads the register reset values.
// A stall at the output backs up stage by stage; empty stages still fill,
// so bubbles close up and no beat is dropped or repeated.
module affine_warp_source_address
    import awsa_pkg::*;
#(
    parameter int OUT_WIDTH  = OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT = OUT_HEIGHT_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input coordinates
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_W-1:0]     out_x,
    input  logic [COORD_W-1:0]     out_y,
    // result
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   hit,
    output logic [SRC_COORD_W-1:0] src_x,
    output logic [SRC_COORD_W-1:0] src_y,
    output logic [IDX_W-1:0]       src_index,
    // register writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic signed [COEF_W-1:0] coef_xx_reg;
    logic signed [COEF_W-1:0] coef_xy_reg;
    logic signed [COEF_W-1:0] offset_x_reg;
    logic signed [COEF_W-1:0] coef_yx_reg;
    logic signed [COEF_W-1:0] coef_yy_reg;
    logic signed [COEF_W-1:0] offset_y_reg;
    logic [DIM_W-1:0]         src_width_reg;
    logic [DIM_W-1:0]         src_height_reg;

    // Dimensions above the largest source size count as the largest size
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;

    // Stage links
    logic   s1_valid;
    logic   s1_ready;
    mul_t   s1_data;
    logic   s2_valid;
    logic   s2_ready;
    sum_t   s2_data;
    logic   s3_valid;
    logic   s3_ready;
    bound_t s3_data;

    // Register writes; writes must only come while the pipeline is empty, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_xx_reg    <= COEF_ONE;
            coef_xy_reg    <= COEF_ZERO;
            offset_x_reg   <= COEF_ZERO;
            coef_yx_reg    <= COEF_ZERO;
            coef_yy_reg    <= COEF_ONE;
            offset_y_reg   <= COEF_ZERO;
            src_width_reg  <= DIM_RST;
            src_height_reg <= DIM_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_COEF_XX:    coef_xx_reg    <= cfg_data[COEF_W-1:0];
                REG_COEF_XY:    coef_xy_reg    <= cfg_data[COEF_W-1:0];
                REG_OFFSET_X:   offset_x_reg   <= cfg_data[COEF_W-1:0];
                REG_COEF_YX:    coef_yx_reg    <= cfg_data[COEF_W-1:0];
                REG_COEF_YY:    coef_yy_reg    <= cfg_data[COEF_W-1:0];
                REG_OFFSET_Y:   offset_y_reg   <= cfg_data[COEF_W-1:0];
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data[DIM_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_data[DIM_W-1:0];
                default:        ;
            endcase
        end
    end

    assign src_w = (src_width_reg  > SRC_DIM_MAX) ? SRC_DIM_MAX : src_width_reg;
    assign src_h = (src_height_reg > SRC_DIM_MAX) ? SRC_DIM_MAX : src_height_reg;

    // Stage 1: products
    awsa_mul_stage #(
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT)
    ) u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .up_ready   (in_ready),
        .out_x      (out_x),
        .out_y      (out_y),
        .coef_xx    (coef_xx_reg),
        .coef_xy    (coef_xy_reg),
        .coef_yx    (coef_yx_reg),
        .coef_yy    (coef_yy_reg),
        .down_valid (s1_valid),
        .down_ready (s1_ready),
        .down_data  (s1_data)
    );

    // Stage 2: mapped point
    awsa_sum_stage u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s1_valid),
        .up_ready   (s1_ready),
        .up_data    (s1_data),
        .offset_x   (offset_x_reg),
        .offset_y   (offset_y_reg),
        .down_valid (s2_valid),
        .down_ready (s2_ready),
        .down_data  (s2_data)
    );

    // Stage 3: inside test and truncation
    awsa_bound_stage #(
        .FRAC_BITS  (FRAC_BITS)
    ) u_bound (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s2_valid),
        .up_ready   (s2_ready),
        .up_data    (s2_data),
        .src_w      (src_w),
        .src_h      (src_h),
        .down_valid (s3_valid),
        .down_ready (s3_ready),
        .down_data  (s3_data)
    );

    // Stage 4: linear index, holds the result until taken
    awsa_index_stage u_index (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s3_valid),
        .up_ready   (s3_ready),
        .up_data    (s3_data),
        .src_w      (src_w),
        .down_valid (out_valid),
        .down_ready (out_ready),
        .hit        (hit),
        .src_x      (src_x),
        .src_y      (src_y),
        .src_index  (src_index)
    );

    // A miss never carries a nonzero address
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (src_x == '0 && src_y == '0 && src_index == '0))
        else $error("miss result carries a nonzero address");

    // A hit column stays inside the source width
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> ({1'b0, src_x} < src_w))
        else $error("hit column outside source width");

    // The input side only backs up when the output holds a beat that is not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while output is free");

endmodule

// ===== hdl/awsa_mul_stage.sv =====
// Stage 1: four coefficient products and the output frame check.
module awsa_mul_stage
    import awsa_pkg::*;
#(
    parameter int OUT_WIDTH  = OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT = OUT_HEIGHT_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_ready,
    input  logic [COORD_W-1:0]       out_x,
    input  logic [COORD_W-1:0]       out_y,
    input  logic signed [COEF_W-1:0] coef_xx,
    input  logic signed [COEF_W-1:0] coef_xy,
    input  logic signed [COEF_W-1:0] coef_yx,
    input  logic signed [COEF_W-1:0] coef_yy,
    output logic                     down_valid,
    input  logic                     down_ready,
    output mul_t                     down_data
);

    localparam logic [FRAME_W-1:0] OUT_W_LIM = FRAME_W'(OUT_WIDTH);
    localparam logic [FRAME_W-1:0] OUT_H_LIM = FRAME_W'(OUT_HEIGHT);

    logic                       valid_reg;
    mul_t                       data_reg;
    mul_t                       data_next;
    logic signed [COORD_W:0]    x_s;
    logic signed [COORD_W:0]    y_s;

    assign x_s = $signed({1'b0, out_x});
    assign y_s = $signed({1'b0, out_y});

    always_comb
    begin
        data_next.in_frame = ({{(FRAME_W-COORD_W){1'b0}}, out_x} < OUT_W_LIM) &&
                             ({{(FRAME_W-COORD_W){1'b0}}, out_y} < OUT_H_LIM);
        data_next.prod_xx  = PROD_W'(coef_xx) * PROD_W'(x_s);
        data_next.prod_xy  = PROD_W'(coef_xy) * PROD_W'(y_s);
        data_next.prod_yx  = PROD_W'(coef_yx) * PROD_W'(x_s);
        data_next.prod_yy  = PROD_W'(coef_yy) * PROD_W'(y_s);
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

// ===== hdl/awsa_sum_stage.sv =====
// Stage 2: sum the products and offsets into the mapped source point.
module awsa_sum_stage
    import awsa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_ready,
    input  mul_t                     up_data,
    input  logic signed [COEF_W-1:0] offset_x,
    input  logic signed [COEF_W-1:0] offset_y,
    output logic                     down_valid,
    input  logic                     down_ready,
    output sum_t                     down_data
);

    logic valid_reg;
    sum_t data_reg;
    sum_t data_next;

    always_comb
    begin
        data_next.in_frame = up_data.in_frame;
        data_next.sx = ACC_W'(up_data.prod_xx) + ACC_W'(up_data.prod_xy) + ACC_W'(offset_x);
        data_next.sy = ACC_W'(up_data.prod_yx) + ACC_W'(up_data.prod_yy) + ACC_W'(offset_y);
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

// ===== hdl/awsa_bound_stage.sv =====
// Stage 3: strict inside test against the source rectangle and fraction drop.
module awsa_bound_stage
    import awsa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  sum_t             up_data,
    input  logic [DIM_W-1:0] src_w,
    input  logic [DIM_W-1:0] src_h,
    output logic             down_valid,
    input  logic             down_ready,
    output bound_t           down_data
);

    localparam int PAD_W = ACC_W - DIM_W - FRAC_BITS;

    logic                    valid_reg;
    bound_t                  data_reg;
    bound_t                  data_next;
    logic signed [ACC_W-1:0] wlim;
    logic signed [ACC_W-1:0] hlim;
    logic                    in_rect;

    // Limits are the dimensions moved up to the fixed point
    assign wlim = $signed({{PAD_W{1'b0}}, src_w, {FRAC_BITS{1'b0}}});
    assign hlim = $signed({{PAD_W{1'b0}}, src_h, {FRAC_BITS{1'b0}}});

    always_comb
    begin
        in_rect = up_data.in_frame &&
                  (up_data.sx > 0) && (up_data.sx < wlim) &&
                  (up_data.sy > 0) && (up_data.sy < hlim);
        data_next.hit = in_rect;
        data_next.px  = in_rect ? up_data.sx[FRAC_BITS +: SRC_COORD_W] : '0;
        data_next.py  = in_rect ? up_data.sy[FRAC_BITS +: SRC_COORD_W] : '0;
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

// ===== hdl/awsa_index_stage.sv =====
// Stage 4: linear source index and the output register.
module awsa_index_stage
    import awsa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  bound_t                 up_data,
    input  logic [DIM_W-1:0]       src_w,
    output logic                   down_valid,
    input  logic                   down_ready,
    output logic                   hit,
    output logic [SRC_COORD_W-1:0] src_x,
    output logic [SRC_COORD_W-1:0] src_y,
    output logic [IDX_W-1:0]       src_index
);

    logic                   valid_reg;
    logic                   hit_reg;
    logic [SRC_COORD_W-1:0] src_x_reg;
    logic [SRC_COORD_W-1:0] src_y_reg;
    logic [IDX_W-1:0]       src_index_reg;
    logic [PIX_PROD_W-1:0]  idx_full;
    logic [IDX_W-1:0]       src_index_next;

    // A miss carries zero coordinates, so the index comes out zero as well
    assign idx_full = PIX_PROD_W'(up_data.py) * PIX_PROD_W'(src_w) + PIX_PROD_W'(up_data.px);
    assign src_index_next = idx_full[IDX_W-1:0];

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            hit_reg       <= up_data.hit;
            src_x_reg     <= up_data.px;
            src_y_reg     <= up_data.py;
            src_index_reg <= src_index_next;
        end
    end

    assign down_valid = valid_reg;
    assign hit        = hit_reg;
    assign src_x      = src_x_reg;
    assign src_y      = src_y_reg;
    assign src_index  = src_index_reg;

endmodule

// ===== test/tb_affine_warp_source_address.sv =====
// Self-checking testbench for the inverse affine warp source address generator.
module tb_affine_warp_source_address;
    import awsa_pkg::*;

    // Four register stages from input beat to result beat
    localparam int PIPE_DEPTH      = 4;
    // Cycles without any beat on either channel before the run is called hung
    localparam int QUIET_LIMIT     = 4000;
    localparam int RANDOM_PHASES   = 14;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int MAX_REPORTS     = 10;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
    typedef enum int {SETUP_FIT, SETUP_ROTATE, SETUP_WILD, SETUP_EXTREME} setup_kind_e;

    // One result beat: hit flag, source column and row, linear source index
    typedef struct packed {
        logic                   hit;
        logic [SRC_COORD_W-1:0] col;
        logic [SRC_COORD_W-1:0] row;
        logic [IDX_W-1:0]       lin;
    } src_addr_t;

    // Mirror of the warp registers and the queue of source addresses still owed
    class warp_scoreboard;
        logic signed [COEF_W-1:0] xx, xy, ox, yx, yy, oy;
        logic [DIM_W-1:0]         src_w, src_h;
        src_addr_t                owed_q[$];
        int                       errors;

        function new();
            xx     = COEF_ONE;
            xy     = COEF_ZERO;
            ox     = COEF_ZERO;
            yx     = COEF_ZERO;
            yy     = COEF_ONE;
            oy     = COEF_ZERO;
            src_w  = DIM_RST;
            src_h  = DIM_RST;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_COEF_XX:    xx = data;
                REG_COEF_XY:    xy = data;
                REG_OFFSET_X:   ox = data;
                REG_COEF_YX:    yx = data;
                REG_COEF_YY:    yy = data;
                REG_OFFSET_Y:   oy = data;
                REG_SRC_WIDTH:  src_w = data[DIM_W-1:0];
                REG_SRC_HEIGHT: src_h = data[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        // Map one output pixel back into the source and queue the address it owes
        function void note_coord(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
            longint    px, py, sx, sy, w, h, col, row, lin;
            src_addr_t r;
            w  = longint'((src_w > SRC_DIM_MAX) ? SRC_DIM_MAX : src_w);
            h  = longint'((src_h > SRC_DIM_MAX) ? SRC_DIM_MAX : src_h);
            px = longint'(x);
            py = longint'(y);
            sx = longint'(xx) * px + longint'(xy) * py + longint'(ox);
            sy = longint'(yx) * px + longint'(yy) * py + longint'(oy);
            r  = '0;
            if (px < OUT_WIDTH_DEF && py < OUT_HEIGHT_DEF &&
                sx > 0 && sx < (w << FRAC_BITS_DEF) &&
                sy > 0 && sy < (h << FRAC_BITS_DEF)) begin
                col   = sx >>> FRAC_BITS_DEF;
                row   = sy >>> FRAC_BITS_DEF;
                lin   = row * w + col;
                r.hit = 1'b1;
                r.col = col[SRC_COORD_W-1:0];
                r.row = row[SRC_COORD_W-1:0];
                r.lin = lin[IDX_W-1:0];
            end
            owed_q.push_back(r);
        endfunction

        function void check_result(logic h, logic [SRC_COORD_W-1:0] col,
                                   logic [SRC_COORD_W-1:0] row, logic [IDX_W-1:0] lin);
            src_addr_t want;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result beat with nothing owed: hit=%0b x=%0d y=%0d index=%0d",
                             $realtime, h, col, row, lin);
                return;
            end
            want = owed_q.pop_front();
            if (h !== want.hit || col !== want.col || row !== want.row || lin !== want.lin) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: expected hit=%0b x=%0d y=%0d index=%0d, got hit=%0b x=%0d y=%0d index=%0d",
                             $realtime, want.hit, want.col, want.row, want.lin,
                             h, col, row, lin);
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    // Every input to the block starts at a known value
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic [COORD_W-1:0]     out_x     = '0;
    logic [COORD_W-1:0]     out_y     = '0;
    logic                   out_ready = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_ready;
    logic                   out_valid;
    logic                   hit;
    logic [SRC_COORD_W-1:0] src_x;
    logic [SRC_COORD_W-1:0] src_y;
    logic [IDX_W-1:0]       src_index;

    warp_scoreboard board;
    int             send_idle_pct = 0;   // chance per cycle that the sender holds off
    int             stall_pct     = 0;   // chance per cycle that the receiver stalls
    int             n_coords      = 0;   // coordinate beats accepted so far
    int             quiet_cycles  = 0;   // consecutive cycles with no beat anywhere

    affine_warp_source_address i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .src_x     (src_x),
        .src_y     (src_y),
        .src_index (src_index),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: decide readiness at each falling edge, so it is stable at the next rising edge
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= stall_pct);
    end

    // Watch both channels at the rising edge. Note the coordinate first, so a result in
    // the same cycle could never be checked against a queue missing its own entry.
    always @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            board.note_coord(out_x, out_y);
            n_coords++;
        end
        if (out_valid && out_ready)
            board.check_result(hit, src_x, src_y, src_index);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // Hang detection: give up once nothing has moved for too long
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_affine_warp_source_address NOT OK");
        $finish;
    end

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 71; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 71; end
            default:       begin send_idle_pct = 16; stall_pct = 16; end
        endcase
    endtask

    // Present one coordinate beat and hold it until the monitor sees it taken.
    // Called at a falling edge; returns at a falling edge with valid still high,
    // so back-to-back beats go out without a bubble.
    task automatic send_coord(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        int target;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        out_x    = x;
        out_y    = y;
        target   = n_coords + 1;
        do
            @(negedge clk);
        while (n_coords < target);
    endtask

    // Drop valid and hold off until every owed result is back and the pipe is empty
    task automatic drain();
        in_valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Program all eight registers; the size registers get junk in their unused upper
    // bits half the time, which the block must ignore
    task automatic load_transform(input logic [COEF_W-1:0] m_xx, input logic [COEF_W-1:0] m_xy,
                                  input logic [COEF_W-1:0] off_x, input logic [COEF_W-1:0] m_yx,
                                  input logic [COEF_W-1:0] m_yy, input logic [COEF_W-1:0] off_y,
                                  input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom_range(1) ? $urandom : '0;
        write_reg(REG_COEF_XX, m_xx);
        write_reg(REG_COEF_XY, m_xy);
        write_reg(REG_OFFSET_X, off_x);
        write_reg(REG_COEF_YX, m_yx);
        write_reg(REG_COEF_YY, m_yy);
        write_reg(REG_OFFSET_Y, off_y);
        write_reg(REG_SRC_WIDTH, {junk[CFG_DATA_W-1:DIM_W], w});
        write_reg(REG_SRC_HEIGHT, {junk[CFG_DATA_W-DIM_W-1:0], h});
    endtask

    // Source size: mostly small and mid sizes, with the edges and oversized values mixed in
    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 7))
            0:       return DIM_RST;
            1:       return SRC_DIM_MAX;
            2:       return DIM_W'($urandom_range(4097, 8191));
            3, 4:    return DIM_W'($urandom_range(2, 64));
            default: return DIM_W'($urandom_range(65, 4095));
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return COEF_ZERO;
            3:       return 32'hFFFF_FFFF;
            4:       return COEF_ONE;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // Output coordinate: uniform over the frame, with the frame edges now and then
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return COORD_W'(1);
            2:       return {COORD_W{1'b1}} - COORD_W'(1);
            3:       return {COORD_W{1'b1}};
            default: return COORD_W'($urandom_range(0, 2047));
        endcase
    endfunction

    initial
    begin : stimulus
        setup_kind_e      kind;
        logic [DIM_W-1:0] w, h;
        longint           ew, eh, m_xx, m_xy, m_yx, m_yy, off_x, off_y;
        int               phase, i;

        board = new();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Reset registers: unit scale onto a 1x1 source. Every integer point lands on
        // the left or top edge or beyond, so nothing hits.
        set_idling(IDLE_NONE);
        send_coord(0, 0);
        send_coord(2047, 2047);
        send_coord(1, 0);
        drain();

        // Unit scale shifted by half a pixel onto an oversized source that clamps to 4096:
        // every pixel of the frame hits, including all four corners.
        set_idling(IDLE_SENDER);
        load_transform(COEF_ONE, COEF_ZERO, 32'h0000_8000, COEF_ZERO, COEF_ONE, 32'h0000_8000,
                       13'd8191, SRC_DIM_MAX);
        send_coord(0, 0);
        send_coord(2047, 2047);
        send_coord(2047, 0);
        send_coord(0, 2047);
        send_coord(1234, 567);
        drain();

        // 16x16 source, no offset: points exactly on an edge are outside, just within is a hit
        set_idling(IDLE_RECEIVER);
        load_transform(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO,
                       13'd16, 13'd16);
        send_coord(0, 5);
        send_coord(16, 5);
        send_coord(15, 15);
        send_coord(5, 16);
        send_coord(5, 0);
        drain();

        // Most negative and most positive coefficients cancelling against each other
        set_idling(IDLE_BOTH);
        load_transform(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0001,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_0001, SRC_DIM_MAX, SRC_DIM_MAX);
        send_coord(1, 1);
        send_coord(0, 0);
        send_coord(2047, 2047);
        send_coord(2047, 0);
        send_coord(0, 2047);
        drain();

        // Empty source width: never a hit
        set_idling(IDLE_NONE);
        load_transform(COEF_ONE, COEF_ZERO, 32'h0000_8000, COEF_ZERO, COEF_ONE, 32'h0000_8000,
                       '0, 13'd5);
        send_coord(0, 0);
        send_coord(3, 3);
        drain();

        // Mirrored in both axes: right frame edge maps to source column 0, rows hit the
        // bottom edge exactly at zero
        set_idling(IDLE_SENDER);
        load_transform(32'hFFFF_0000, COEF_ZERO, 32'h07FF_FFFF,
                       COEF_ZERO, 32'hFFFF_0000, 32'h0064_0000, 13'd2048, 13'd100);
        send_coord(0, 1);
        send_coord(2047, 1);
        send_coord(5, 0);
        send_coord(5, 100);
        send_coord(5, 99);
        drain();

        // Random phases. Fit and rotate pin the frame centre onto the source centre,
        // so a good share of pixels land inside; wild and extreme mostly miss.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_idling(idle_mode_e'(phase % 4));
            kind = setup_kind_e'($urandom_range(0, 3));
            w    = pick_dim();
            h    = pick_dim();
            ew   = longint'((w > SRC_DIM_MAX) ? SRC_DIM_MAX : w);
            eh   = longint'((h > SRC_DIM_MAX) ? SRC_DIM_MAX : h);
            case (kind)
                SETUP_FIT: begin
                    m_xx = (ew << 16) / 2048 + longint'($urandom_range(0, 64));
                    m_yy = (eh << 16) / 2048 + longint'($urandom_range(0, 64));
                    m_xy = longint'($urandom_range(0, int'(8 * ew)));
                    m_yx = longint'($urandom_range(0, int'(8 * eh)));
                    if ($urandom_range(1)) m_xx = -m_xx;
                    if ($urandom_range(1)) m_yy = -m_yy;
                    if ($urandom_range(1)) m_xy = -m_xy;
                    if ($urandom_range(1)) m_yx = -m_yx;
                end
                default: begin
                    m_xx = longint'($urandom_range(0, int'(64 * ew)));
                    m_yx = longint'($urandom_range(0, int'(64 * eh)));
                    if ($urandom_range(1)) m_xx = -m_xx;
                    if ($urandom_range(1)) m_yx = -m_yx;
                    m_xy = -m_yx;
                    m_yy = m_xx;
                end
            endcase
            off_x = ew * 32768 - (m_xx + m_xy) * 1024
                    + longint'($urandom_range(0, int'(16384 * ew))) - 8192 * ew;
            off_y = eh * 32768 - (m_yx + m_yy) * 1024
                    + longint'($urandom_range(0, int'(16384 * eh))) - 8192 * eh;
            case (kind)
                SETUP_WILD:
                    load_transform($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                   DIM_W'($urandom_range(0, 8191)),
                                   DIM_W'($urandom_range(0, 8191)));
                SETUP_EXTREME:
                    load_transform(pick_extreme(), pick_extreme(), pick_extreme(),
                                   pick_extreme(), pick_extreme(), pick_extreme(),
                                   $urandom_range(1) ? SRC_DIM_MAX : DIM_W'($urandom_range(0, 1)),
                                   $urandom_range(1) ? 13'd8191 : SRC_DIM_MAX);
                default:
                    load_transform(m_xx[COEF_W-1:0], m_xy[COEF_W-1:0], off_x[COEF_W-1:0],
                                   m_yx[COEF_W-1:0], m_yy[COEF_W-1:0], off_y[COEF_W-1:0],
                                   w, h);
            endcase
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                // Once mid-run, hold off the sender until the pipe has fully emptied
                if (phase == 5 && i == ITEMS_PER_PHASE / 2)
                    drain();
                send_coord(pick_coord(), pick_coord());
            end
            drain();
        end

        if (board.errors == 0 && board.pending() == 0)
            $display("tb_affine_warp_source_address OK");
        else
            $display("tb_affine_warp_source_address NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/awsa_pkg.sv
hdl/awsa_mul_stage.sv
hdl/awsa_sum_stage.sv
hdl/awsa_bound_stage.sv
hdl/awsa_index_stage.sv
hdl/affine_warp_source_address.sv
test/tb_affine_warp_source_address.sv
